// File: sv/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

   // Size line and counter widths
   localparam int SIZE_LINE_CHARS = 31;
   localparam int SIZE_BITS       = 32;
   localparam int LINE_CNT_W      = $clog2(SIZE_LINE_CHARS + 1);
   localparam int COUNT_W         = 24;
   localparam int CAP_W           = 25;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Character codes
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_X_LO  = 8'h78;

   // Body decode phase
   typedef enum logic [3:0] {
      PH_SIZE  = 4'b0001,
      PH_DATA  = 4'b0010,
      PH_TRAIL = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   // strtol-style number parse phase
   typedef enum logic [4:0] {
      NP_WS     = 5'b00001,
      NP_SIGN   = 5'b00010,
      NP_ZERO   = 5'b00100,
      NP_DIGITS = 5'b01000,
      NP_END    = 5'b10000
   } num_phase_type;

   // Size line parse state
   typedef struct packed {
      logic                  cr_held;
      logic [LINE_CNT_W-1:0] line_chars;
      num_phase_type         num_phase;
      logic                  minus_seen;
      logic [SIZE_BITS-1:0]  size_value;
   } line_state_type;

   localparam line_state_type LINE_FRESH = '{
      cr_held:    1'b0,
      line_chars: '0,
      num_phase:  NP_WS,
      minus_seen: 1'b0,
      size_value: '0
   };

endpackage

`default_nettype wire

// File: sv/hcbd_line_parser.sv
`default_nettype none

// Size line parser: one byte against the current line state.
// Handles CR holding and the hex number parse of the first line characters.
module hcbd_line_parser (
   input  hcbd_pkg::line_state_type line_st,
   input  logic [7:0]               ch,
   output hcbd_pkg::line_state_type line_nxt,
   output logic                     crlf_seen,
   output logic                     size_bad
);
   import hcbd_pkg::*;

   // One character into the number parser
   function automatic line_state_type feed(line_state_type s, logic [7:0] c);
      line_state_type r;
      logic           is_hex;
      logic [3:0]     dv;
      logic           is_ws;
      logic           sat;
      logic [SIZE_BITS-1:0] acc;
      num_phase_type  lead_ph;
      logic [SIZE_BITS-1:0] lead_val;
      r = s;
      is_hex = 1'b1;
      dv = '0;
      if (c >= CH_0 && c <= CH_9) begin
         dv = 4'(c - CH_0);
      end else if (c >= CH_A_LO && c <= CH_F_LO) begin
         dv = 4'(c - CH_A_LO + 8'd10);
      end else if (c >= CH_A_UP && c <= CH_F_UP) begin
         dv = 4'(c - CH_A_UP + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
      is_ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
              (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
      // shift in a digit, saturating once the top nibble is in use
      sat = |s.size_value[SIZE_BITS-1 -: 4];
      acc = sat ? '1 : {s.size_value[SIZE_BITS-5:0], dv};
      // first character after whitespace or sign
      lead_ph  = NP_END;
      lead_val = s.size_value;
      if (c == CH_0) begin
         lead_ph = NP_ZERO;
      end else if (is_hex) begin
         lead_ph  = NP_DIGITS;
         lead_val = acc;
      end
      if (s.line_chars < LINE_CNT_W'(SIZE_LINE_CHARS)) begin
         r.line_chars = s.line_chars + 1'b1;
         case (s.num_phase)
            NP_WS: begin
               if (is_ws) begin
                  r.num_phase = NP_WS;
               end else if (c == CH_PLUS) begin
                  r.num_phase = NP_SIGN;
               end else if (c == CH_MINUS) begin
                  r.num_phase  = NP_SIGN;
                  r.minus_seen = 1'b1;
               end else begin
                  r.num_phase  = lead_ph;
                  r.size_value = lead_val;
               end
            end
            NP_SIGN: begin
               r.num_phase  = lead_ph;
               r.size_value = lead_val;
            end
            NP_ZERO: begin
               if (c == CH_X_LO || c == CH_X_UP) begin
                  r.num_phase = NP_DIGITS;
               end else if (is_hex) begin
                  r.num_phase  = NP_DIGITS;
                  r.size_value = acc;
               end else begin
                  r.num_phase = NP_END;
               end
            end
            NP_DIGITS: begin
               if (is_hex) begin
                  r.size_value = acc;
               end else begin
                  r.num_phase = NP_END;
               end
            end
            default: begin
               r.num_phase = s.num_phase;
            end
         endcase
      end
      return r;
   endfunction

   line_state_type held;

   // A held CR not followed by LF counts as a line character
   always_comb begin
      held = line_st;
      if (line_st.cr_held) begin
         held.cr_held = 1'b0;
         held = feed(held, CH_CR);
      end
      if (ch == CH_CR) begin
         line_nxt = held;
         line_nxt.cr_held = 1'b1;
      end else begin
         line_nxt = feed(held, ch);
      end
   end

   assign crlf_seen = line_st.cr_held && (ch == CH_LF);
   assign size_bad  = line_st.minus_seen || (line_st.size_value == '0);

endmodule

`default_nettype wire

// File: sv/http_chunked_body_decoder.sv
// rsp_valid rises once the accepted input word has passed the input register and
// then the result register, where the result waits until rsp_ready takes it.
// One body byte per cycle while rsp_ready keeps the result register moving;
// rsp_ready passes straight to req_ready, so a full pipe still moves.
// Reset (synchronous, active high) returns the decoder to the size line
// start, clears the counts and sets the capacity to 2^24.
`default_nettype none

module http_chunked_body_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_body_byte,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_payload_byte,
   output logic                      rsp_has_byte,
   output logic                      rsp_finished,
   output logic                      rsp_stop_cause,
   output logic [hcbd_pkg::COUNT_W-1:0] rsp_decoded_length,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [hcbd_pkg::CAP_W-1:0] csr_output_capacity
);
   import hcbd_pkg::*;

   // Input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   // Decode state
   phase_type            phase_ff, phase_in;
   line_state_type       line_ff, line_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic [COUNT_W-1:0]   emit_ff, emit_in;
   logic [COUNT_W-1:0]   limit_ff, limit_in;
   logic [CAP_W-1:0]     cap_m1;

   // Result register
   logic               rsp_vld_ff, rsp_vld_in;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_has_ff, rsp_fin_ff, rsp_cause_ff;
   logic [COUNT_W-1:0] rsp_len_ff;

   // Parser outputs and per-word decisions
   line_state_type parsed;
   logic           crlf_seen, size_bad;
   logic           has, stop, produce;

   hcbd_line_parser u_parser (
      .line_st   (line_ff),
      .ch        (in_byte_ff),
      .line_nxt  (parsed),
      .crlf_seen (crlf_seen),
      .size_bad  (size_bad)
   );

   // Handshakes
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign in_vld_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   // Emit limit: capacity minus one, clipped to the count range
   assign cap_m1   = csr_output_capacity - 1'b1;
   assign limit_in = (csr_output_capacity == '0) ? '0 :
                     (cap_m1[CAP_W-1] ? COUNT_MAX : cap_m1[COUNT_W-1:0]);

   // Per-word state update
   always_comb begin
      phase_in = phase_ff;
      line_in  = line_ff;
      left_in  = left_ff;
      emit_in  = emit_ff;
      has      = 1'b0;
      stop     = 1'b0;
      case (phase_ff)
         PH_DATA: begin
            left_in = left_ff - 1'b1;
            if (emit_ff < limit_ff) begin
               has     = 1'b1;
               emit_in = emit_ff + 1'b1;
            end
            if (left_ff == SIZE_BITS'(1)) begin
               phase_in = PH_TRAIL;
               line_in  = LINE_FRESH;
            end
         end
         PH_TRAIL: begin
            // optional CR LF after the payload
            if (!(!line_ff.cr_held && in_byte_ff == CH_CR)) begin
               phase_in = PH_SIZE;
            end
            line_in = (line_ff.cr_held && in_byte_ff == CH_LF) ? LINE_FRESH : parsed;
         end
         PH_SIZE: begin
            if (crlf_seen) begin
               if (size_bad) begin
                  phase_in = PH_DONE;
                  stop     = 1'b1;
               end else begin
                  phase_in = PH_DATA;
                  left_in  = line_ff.size_value;
                  line_in  = LINE_FRESH;
               end
            end else begin
               line_in = parsed;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      // the last byte always restarts the body
      if (in_last_ff) begin
         phase_in = PH_SIZE;
         line_in  = LINE_FRESH;
         left_in  = '0;
         emit_in  = '0;
      end
   end

   assign produce    = (phase_ff != PH_DONE) && (has || stop || in_last_ff);
   assign rsp_vld_in = (advance && produce) ? 1'b1 :
                       (rsp_ready ? 1'b0 : rsp_vld_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         phase_ff   <= PH_SIZE;
         line_ff    <= LINE_FRESH;
         left_ff    <= '0;
         emit_ff    <= '0;
         limit_ff   <= COUNT_MAX;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            phase_ff <= phase_in;
            line_ff  <= line_in;
            left_ff  <= left_in;
            emit_ff  <= emit_in;
         end
         if (csr_valid) begin
            limit_ff <= limit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_body_byte;
         in_last_ff <= req_is_last;
      end
      if (advance && produce) begin
         rsp_byte_ff  <= has ? in_byte_ff : 8'h00;
         rsp_has_ff   <= has;
         rsp_fin_ff   <= stop || in_last_ff;
         rsp_cause_ff <= !stop && in_last_ff;
         // count reported before the end-of-body clear
         rsp_len_ff   <= has ? (emit_ff + 1'b1) : emit_ff;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_has_byte       = rsp_has_ff;
   assign rsp_finished       = rsp_fin_ff;
   assign rsp_stop_cause     = rsp_cause_ff;
   assign rsp_decoded_length = rsp_len_ff;

   // Checks
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_payload_byte == 8'h00)
      else $error("payload byte not zero without a decoded byte");

   a_cause_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_finished |-> !rsp_stop_cause)
      else $error("stop cause set on an unfinished result");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != '0)
      else $error("data phase with no bytes left");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= limit_ff)
      else $error("emitted count beyond the limit");

   a_stop_to_done: assert property (@(posedge clock) disable iff (reset)
      advance && stop && !in_last_ff |=> phase_ff == PH_DONE)
      else $error("stop did not park the decoder");

endmodule

`default_nettype wire

// File: verif/http_chunked_body_decoder_tb.sv
`default_nettype none

module http_chunked_body_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hcbd_pkg::*;

   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STALL    = 40;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 55;
   localparam logic [7:0] CH_SEMI = ";";

   typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_WORD} row_kind_type;
   typedef enum logic [1:0] {END_ZERO, END_MINUS, END_BARE_PREFIX, END_CUT} ending_type;

   // One decoder output word
   typedef struct packed {
      logic [7:0]         payload_byte;
      logic               has_byte;
      logic               finished;
      logic               stop_cause;
      logic [COUNT_W-1:0] decoded_length;
   } decoded_word_type;

   typedef struct {
      logic [7:0]       body_byte;
      logic             is_last;
      row_kind_type     kind;
      decoded_word_type word;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_body_byte = '0;
   logic                 req_is_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_has_byte;
   logic                 rsp_finished;
   logic                 rsp_stop_cause;
   logic [COUNT_W-1:0]   rsp_decoded_length;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAP_W-1:0]     csr_output_capacity = '0;

   http_chunked_body_decoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_body_byte      (req_body_byte),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_finished       (rsp_finished),
      .rsp_stop_cause     (rsp_stop_cause),
      .rsp_decoded_length (rsp_decoded_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_output_capacity(csr_output_capacity)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   decoded_word_type predicted_words[$];
   stim_row_type     directed_rows[$];
   logic [7:0]       body_bytes[$];
   int               mismatch_count = 0;
   bit               quiet_tail = 1'b0;
   bit               long_hold_pending = 1'b0;

   // Decoder mirror state
   phase_type            dec_phase;
   logic                 cr_pending;
   int unsigned          line_count;
   num_phase_type        num_state;
   logic                 minus_flag;
   logic [SIZE_BITS-1:0] size_acc;
   logic [SIZE_BITS-1:0] chunk_left;
   logic [COUNT_W-1:0]   emitted;
   logic [CAP_W-1:0]     capacity;

   logic [CAP_W-1:0] capacity_plan [NUM_PHASES] = '{
      25'd16777216, 25'd1, 25'd0, 25'h1FFFFFF, 25'd2, 25'd3, 25'd5, 25'd16777215
   };

   function automatic void line_restart();
      cr_pending = 1'b0;
      line_count = 0;
      num_state  = NP_WS;
      minus_flag = 1'b0;
      size_acc   = '0;
   endfunction

   function automatic void body_restart();
      dec_phase  = PH_SIZE;
      line_restart();
      chunk_left = '0;
      emitted    = '0;
   endfunction

   function automatic int hex_value(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
      if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
      return -1;
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   // Size value saturates instead of wrapping
   function automatic void add_digit(int d);
      logic [SIZE_BITS-1:0] top;
      logic [SIZE_BITS-1:0] dv;
      top = '1;
      dv  = SIZE_BITS'(d);
      if (size_acc > (top - dv) / 16) size_acc = top;
      else size_acc = size_acc * 16 + dv;
   endfunction

   // strtol-style parse of one size line character
   function automatic void parse_char(logic [7:0] c);
      int d;
      bit lead;
      if (line_count >= SIZE_LINE_CHARS) return;
      line_count++;
      d    = hex_value(c);
      lead = (num_state == NP_SIGN);
      case (num_state)
         NP_WS: begin
            if (!is_space(c)) begin
               if (c == CH_PLUS) num_state = NP_SIGN;
               else if (c == CH_MINUS) begin
                  minus_flag = 1'b1;
                  num_state  = NP_SIGN;
               end else lead = 1'b1;
            end
         end
         NP_ZERO: begin
            if (c == CH_X_LO || c == CH_X_UP) num_state = NP_DIGITS;
            else if (d >= 0) begin
               add_digit(d);
               num_state = NP_DIGITS;
            end else num_state = NP_END;
         end
         NP_DIGITS: begin
            if (d >= 0) add_digit(d);
            else num_state = NP_END;
         end
         default: ;
      endcase
      if (lead) begin
         if (c == CH_0) num_state = NP_ZERO;
         else if (d >= 0) begin
            add_digit(d);
            num_state = NP_DIGITS;
         end else num_state = NP_END;
      end
   endfunction

   // Size line byte; returns 1 when the line stops decoding
   function automatic bit size_line_byte(logic [7:0] c);
      if (cr_pending) begin
         if (c == CH_LF) begin
            if (minus_flag || size_acc == '0) begin
               dec_phase = PH_DONE;
               return 1'b1;
            end
            chunk_left = size_acc;
            dec_phase  = PH_DATA;
            line_restart();
            return 1'b0;
         end
         cr_pending = 1'b0;
         parse_char(CH_CR);
      end
      if (c == CH_CR) cr_pending = 1'b1;
      else parse_char(c);
      return 1'b0;
   endfunction

   // Expected output for one accepted body byte; returns 1 if a word results
   function automatic bit decode_byte(input logic [7:0] c, input logic last,
                                      output decoded_word_type w);
      logic [CAP_W-1:0] limit;
      bit has;
      bit stop;
      has   = 1'b0;
      stop  = 1'b0;
      w     = '0;
      limit = (capacity == '0) ? '0 : capacity - 1'b1;
      if (limit > CAP_W'(COUNT_MAX)) limit = CAP_W'(COUNT_MAX);
      if (dec_phase == PH_DONE) begin
         if (last) body_restart();
         return 1'b0;
      end
      case (dec_phase)
         PH_DATA: begin
            chunk_left--;
            if (emitted < limit) begin
               has = 1'b1;
               emitted++;
            end
            if (chunk_left == '0) begin
               dec_phase  = PH_TRAIL;
               cr_pending = 1'b0;
            end
         end
         PH_TRAIL: begin
            if (cr_pending) begin
               dec_phase = PH_SIZE;
               line_restart();
               if (c != CH_LF) begin
                  cr_pending = 1'b1;
                  stop = size_line_byte(c);
               end
            end else if (c == CH_CR) begin
               cr_pending = 1'b1;
            end else begin
               dec_phase = PH_SIZE;
               line_restart();
               stop = size_line_byte(c);
            end
         end
         default: stop = size_line_byte(c);
      endcase
      if (!has && !stop && !last) return 1'b0;
      w.payload_byte   = has ? c : 8'h00;
      w.has_byte       = has;
      w.finished       = stop || last;
      w.stop_cause     = !stop && last;
      w.decoded_length = emitted;
      if (last) body_restart();
      return 1'b1;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
      if (nib < 10) return CH_0 + 8'(nib);
      return (upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
   endfunction

   // Size line with random formatting: whitespace, sign, prefix, extension
   function automatic void put_size_line(logic [31:0] size);
      int  ndig;
      int  i;
      bit  upper;
      upper = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 24) == 0) begin
         // line full of blanks: digits fall past the parsed part
         repeat (SIZE_LINE_CHARS + 1) body_bytes.push_back(CH_SP);
      end else if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 4))
               0: body_bytes.push_back(CH_SP);
               1: body_bytes.push_back(CH_TAB);
               2: body_bytes.push_back(CH_VT);
               3: body_bytes.push_back(CH_FF);
               default: body_bytes.push_back(CH_LF);
            endcase
         end
      end
      if ($urandom_range(0, 7) == 0) body_bytes.push_back(CH_PLUS);
      if ($urandom_range(0, 5) == 0) begin
         body_bytes.push_back(CH_0);
         body_bytes.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
      end
      if ($urandom_range(0, 5) == 0) body_bytes.push_back(CH_0);
      ndig = 1;
      for (i = 1; i < 8; i++) if (size[4*i +: 4] != 4'h0) ndig = i + 1;
      for (i = ndig - 1; i >= 0; i--) body_bytes.push_back(hex_char(size[4*i +: 4], upper));
      if ($urandom_range(0, 4) == 0) begin
         body_bytes.push_back(CH_SEMI);
         repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6))
            body_bytes.push_back(8'($urandom_range(33, 126)));
         if ($urandom_range(0, 3) == 0) begin
            body_bytes.push_back(CH_CR);   // lone CR inside the extension
            body_bytes.push_back("z");
         end
      end
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
   endfunction

   // One whole body, mostly well formed, some noise and broken shapes
   function automatic void build_body();
      int         nch;
      int         k;
      int         sz;
      int         take;
      ending_type ending;
      body_bytes.delete();
      case ($urandom_range(0, 19))
         0, 1: repeat ($urandom_range(1, 12)) body_bytes.push_back(rand_byte());
         2: begin
            // oversized count saturates; body ends inside the chunk
            body_bytes.push_back(hex_char(4'($urandom_range(1, 15)), 1'b1));
            repeat ($urandom_range(8, 11))
               body_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
            repeat ($urandom_range(1, 6)) body_bytes.push_back(rand_byte());
         end
         default: begin
            nch = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
               7:       ending = END_MINUS;
               8:       ending = END_BARE_PREFIX;
               9:       ending = END_CUT;
               default: ending = END_ZERO;
            endcase
            for (k = 0; k < nch; k++) begin
               sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
               put_size_line(sz);
               take = (ending == END_CUT && k == nch - 1) ? $urandom_range(1, sz) : sz;
               repeat (take) body_bytes.push_back(rand_byte());
               if (take == sz) begin
                  case ($urandom_range(0, 19))
                     0: ;
                     1: body_bytes.push_back(CH_CR);
                     default: begin
                        body_bytes.push_back(CH_CR);
                        body_bytes.push_back(CH_LF);
                     end
                  endcase
               end
            end
            case (ending)
               END_ZERO: put_size_line(0);
               END_MINUS: begin
                  body_bytes.push_back(CH_MINUS);
                  body_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                  body_bytes.push_back(CH_CR);
                  body_bytes.push_back(CH_LF);
               end
               END_BARE_PREFIX: begin
                  body_bytes.push_back(CH_0);
                  body_bytes.push_back(CH_X_LO);
                  body_bytes.push_back(CH_SEMI);
                  body_bytes.push_back(CH_CR);
                  body_bytes.push_back(CH_LF);
               end
               default: ;
            endcase
            // trailer junk after the stop
            if (ending != END_CUT) repeat ($urandom_range(0, 3)) body_bytes.push_back(rand_byte());
         end
      endcase
      if (body_bytes.size() == 0) body_bytes.push_back(rand_byte());
   endfunction

   function automatic void add_row(logic [7:0] b, logic last = 1'b0,
                                   row_kind_type kind = ROW_PREDICT, logic [7:0] pb = 8'h00,
                                   logic has = 1'b0, logic fin = 1'b0, logic cause = 1'b0,
                                   logic [COUNT_W-1:0] len = '0);
      stim_row_type r;
      r.body_byte = b;
      r.is_last   = last;
      r.kind      = kind;
      r.word      = {pb, has, fin, cause, len};
      directed_rows.push_back(r);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Offer one body byte, wait for the handshake, record what it should produce
   task automatic send_word(input logic [7:0] b, input logic last, input row_kind_type kind,
                            input decoded_word_type typed);
      decoded_word_type w;
      bit produced;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_body_byte <= b;
      req_is_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = decode_byte(b, last, w);
      case (kind)
         ROW_PREDICT: if (produced) predicted_words.push_back(w);
         ROW_WORD:    predicted_words.push_back(typed);
         default:     ;
      endcase
      @(negedge clock);
   endtask

   // Block goes idle: all words out, then room for in-flight bytes with no word
   task automatic drain_results();
      req_valid <= 1'b0;
      while (predicted_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_output_capacity <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each delivered word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      decoded_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (predicted_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word: byte %h has %b fin %b cause %b len %0d",
                                    rsp_payload_byte, rsp_has_byte, rsp_finished,
                                    rsp_stop_cause, rsp_decoded_length));
         end else begin
            want = predicted_words.pop_front();
            if (rsp_payload_byte !== want.payload_byte)
               flag_mismatch($sformatf("payload_byte got %h want %h",
                                       rsp_payload_byte, want.payload_byte));
            if (rsp_has_byte !== want.has_byte)
               flag_mismatch($sformatf("has_byte got %b want %b", rsp_has_byte, want.has_byte));
            if (rsp_finished !== want.finished)
               flag_mismatch($sformatf("finished got %b want %b", rsp_finished, want.finished));
            if (rsp_stop_cause !== want.stop_cause)
               flag_mismatch($sformatf("stop_cause got %b want %b",
                                       rsp_stop_cause, want.stop_cause));
            if (rsp_decoded_length !== want.decoded_length)
               flag_mismatch($sformatf("decoded_length got %0d want %0d",
                                       rsp_decoded_length, want.decoded_length));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int         phase_idx;
      int         sent;
      logic [7:0] b;

      capacity = 25'd16777216;
      body_restart();

      // prefix, sign, extension, then two payload bytes at the value extremes
      add_row(CH_SP);
      add_row(CH_PLUS);
      add_row(CH_0);
      add_row(CH_X_LO);
      add_row("2");
      add_row(CH_SEMI);
      add_row(CH_CR);
      add_row(CH_LF);
      add_row(8'h00, 1'b0, ROW_WORD, 8'h00, 1'b1, 1'b0, 1'b0, 24'd1);
      add_row(8'hFF, 1'b0, ROW_WORD, 8'hFF, 1'b1, 1'b0, 1'b0, 24'd2);
      add_row(CH_CR);
      add_row(CH_LF);
      // negative size with a lone CR in the line stops decoding
      add_row(CH_MINUS);
      add_row(CH_CR);
      add_row("q");
      add_row(CH_CR);
      add_row(CH_LF, 1'b0, ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b0, 24'd2);
      add_row("k", 1'b1, ROW_SILENT);
      // bare 0x prefix reads as zero; stop lands on the last byte
      add_row(CH_0);
      add_row(CH_X_LO);
      add_row(CH_CR);
      add_row(CH_LF, 1'b1, ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b0, 24'd0);
      // body ends inside a chunk
      add_row("2");
      add_row(CH_CR);
      add_row(CH_LF);
      add_row("A", 1'b1, ROW_WORD, "A", 1'b1, 1'b1, 1'b1, 24'd1);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].body_byte, directed_rows[i].is_last,
                   directed_rows[i].kind, directed_rows[i].word);

      // random bodies, one capacity setting per phase
      for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
         drain_results();
         write_capacity(capacity_plan[phase_idx]);
         if (phase_idx == NUM_PHASES - 1) quiet_tail = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_body();
            while (body_bytes.size() != 0) begin
               b = body_bytes.pop_front();
               send_word(b, body_bytes.size() == 0, ROW_PREDICT, '0);
               sent++;
               // long result stall while input keeps coming
               if (phase_idx == 0 && sent == 20) long_hold_pending = 1'b1;
            end
         end
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
